// ===== hw/rtl/cme_pkg.sv =====
// Shared types and constants for the cartridge mapper with serial EEPROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cme_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SET,
    ST_ORBIT,
    ST_OUT,
    ST_FETCH,
    ST_INIT
  } state_e;

  typedef struct packed {
    logic fetch;
    logic exec;
    logic sweep_clear;
    logic sweep_set;
    logic sweep_or;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic need_clear;
    logic need_set;
    logic need_or;
  } sts_t;

  localparam logic [1:0] SRC_MAPPER = 2'd0;
  localparam logic [1:0] SRC_ROM = 2'd1;
  localparam logic [1:0] SRC_SYSTEM = 2'd2;
  localparam logic [1:0] SRC_ABSORB = 2'd3;

  localparam logic [7:0] TILT_ARM = 8'h55;
  localparam logic [7:0] TILT_CAPTURE = 8'hAA;
  localparam logic [15:0] TILT_CENTRE = 16'h81D0;
  localparam logic [15:0] TILT_RESET = 16'h8000;

  localparam logic [3:0] OP_EWDS = 4'h0;
  localparam logic [3:0] OP_WRAL = 4'h1;
  localparam logic [3:0] OP_ERAL = 4'h2;
  localparam logic [3:0] OP_EWEN = 4'h3;

endpackage
`default_nettype wire

// ===== hw/rtl/cme_ctrl.sv =====
// Controller of the mapper: sequences one request and any EEPROM word sweep.
// Depends on cme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cme_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output cme_pkg::cmd_t        cmd_o,
  input  wire cme_pkg::sts_t   sts_i
);

  cme_pkg::state_e state_q, state_d;

  // After reset the EEPROM array is filled with ones before any request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cme_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cme_pkg::ST_INIT: begin
        if (sts_i.sweep_last) state_d = cme_pkg::ST_IDLE;
      end
      cme_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cme_pkg::ST_FETCH;
      end
      cme_pkg::ST_FETCH: state_d = cme_pkg::ST_EXEC;
      cme_pkg::ST_EXEC: begin
        if (sts_i.need_clear) state_d = cme_pkg::ST_CLEAR;
        else if (sts_i.need_set) state_d = cme_pkg::ST_SET;
        else if (sts_i.need_or) state_d = cme_pkg::ST_ORBIT;
        else state_d = cme_pkg::ST_OUT;
      end
      cme_pkg::ST_CLEAR, cme_pkg::ST_SET, cme_pkg::ST_ORBIT: begin
        if (sts_i.sweep_last) state_d = cme_pkg::ST_OUT;
      end
      cme_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = cme_pkg::ST_IDLE;
      end
      default: state_d = cme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      cme_pkg::ST_INIT: cmd_o.sweep_set = 1'b1;
      cme_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.out_load = in_valid_i;
      end
      cme_pkg::ST_FETCH: cmd_o.fetch = 1'b1;
      cme_pkg::ST_EXEC: cmd_o.exec = 1'b1;
      cme_pkg::ST_CLEAR: cmd_o.sweep_clear = 1'b1;
      cme_pkg::ST_SET: cmd_o.sweep_set = 1'b1;
      cme_pkg::ST_ORBIT: cmd_o.sweep_or = 1'b1;
      cme_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cme_pkg::ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_fetch_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == cme_pkg::ST_FETCH)) else $error("no fetch");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/cme_datapath.sv =====
// Datapath of the mapper: bank and enable registers, tilt latch, serial EEPROM.
// Depends on cme_pkg; driven by cme_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module cme_datapath #(
  parameter int BankBits = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cme_pkg::cmd_t      cmd_i,
  output cme_pkg::sts_t           sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               mode_i,
  input  wire logic [15:0]        address_i,
  input  wire logic [7:0]         write_data_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  output logic [7:0]              read_data_o,
  output logic [21:0]             rom_address_o,
  output logic [1:0]              access_source_o,
  output logic [7:0]              current_bank_o
);

  localparam int Depth = 128;

  // Request capture.
  logic mode_q;
  logic [15:0] addr_q;
  logic [7:0] wdata_q;
  logic signed [15:0] ax_q, ay_q;

  logic [7:0] mask_q;
  logic [7:0] bank_q, bank_d;
  logic en_lo_q, en_lo_d, en_hi_q, en_hi_d;
  logic [15:0] tx_q, tx_d, ty_q, ty_d;
  logic armed_q, armed_d;
  logic dout_q, dout_d, din_q, din_d, sck_q, sck_d, cs_q, cs_d;
  logic [10:0] cmd_sh_q, cmd_sh_d;
  logic [15:0] out_sh_q, out_sh_d;
  logic [4:0] bits_q, bits_d;
  logic ewen_q, ewen_d;
  logic [7:0] rdata_q, rdata_d;
  logic [21:0] raddr_q, raddr_d;
  logic [1:0] src_q, src_d;

  logic [15:0] mem_q [Depth];
  logic [15:0] rd_q;
  logic [6:0] sweep_q;
  logic [15:0] fill_q, fill_d;
  logic need_clear_d, need_set_d, need_or_d;
  logic [6:0] widx;
  logic wr_single;
  logic [15:0] wr_single_data;

  // Tilt products; one multiply each, registered in the capture request.
  function automatic logic [15:0] tilt(input logic signed [15:0] a);
    logic signed [23:0] p;
    logic [23:0] m;
    logic signed [23:0] q;
    begin
      p = 24'(a) * 24'sd112;
      m = p[23] ? 24'(-p) : 24'(p);
      q = p[23] ? -$signed({12'd0, m[23:12]}) : $signed({12'd0, m[23:12]});
      tilt = cme_pkg::TILT_CENTRE + q[15:0];
    end
  endfunction

  // A command addresses the word shifted in with this request; data bits use
  // the word of the command already held.
  assign widx = (bits_q == 5'd0) ? {cmd_sh_q[5:0], wdata_q[1]} : cmd_sh_q[6:0];

  always_comb begin
    logic en;
    logic [3:0] op;
    logic [10:0] nsh;
    logic [3:0] obit;
    bank_d = bank_q; en_lo_d = en_lo_q; en_hi_d = en_hi_q;
    tx_d = tx_q; ty_d = ty_q; armed_d = armed_q;
    dout_d = dout_q; din_d = din_q; sck_d = sck_q; cs_d = cs_q;
    cmd_sh_d = cmd_sh_q; out_sh_d = out_sh_q; bits_d = bits_q; ewen_d = ewen_q;
    rdata_d = 8'd0; raddr_d = 22'd0; src_d = cme_pkg::SRC_SYSTEM;
    need_clear_d = 1'b0; need_set_d = 1'b0; need_or_d = 1'b0; fill_d = fill_q;
    wr_single = 1'b0; wr_single_data = rd_q;
    en = en_lo_q && en_hi_q;
    nsh = '0; op = '0; obit = '0;
    if (!mode_q) begin
      if (addr_q[15:13] == 3'b010 || addr_q[15:13] == 3'b011) begin
        src_d = cme_pkg::SRC_ROM;
        raddr_d = {bank_q, addr_q[13:0]};
      end else if (addr_q[15:13] == 3'b101) begin
        src_d = cme_pkg::SRC_MAPPER;
        rdata_d = 8'hFF;
        if (en && !addr_q[12]) begin
          case (addr_q[7:4])
            4'h2: rdata_d = tx_q[7:0];
            4'h3: rdata_d = tx_q[15:8];
            4'h4: rdata_d = ty_q[7:0];
            4'h5: rdata_d = ty_q[15:8];
            4'h6: rdata_d = 8'h00;
            4'h8: rdata_d = {cs_q, sck_q, 4'd0, din_q, dout_q};
            default: rdata_d = 8'hFF;
          endcase
        end
      end
    end else begin
      src_d = cme_pkg::SRC_ABSORB;
      case (addr_q[15:13])
        3'b000: en_lo_d = (wdata_q[3:0] == 4'hA);
        3'b001: bank_d = wdata_q & mask_q & 8'((9'd1 << BankBits) - 9'd1);
        3'b010: en_hi_d = (wdata_q == 8'h40);
        3'b011: ;
        3'b101: begin
          if (en && !addr_q[12]) begin
            case (addr_q[7:4])
              4'h0: if (wdata_q == cme_pkg::TILT_ARM) begin
                armed_d = 1'b1; tx_d = cme_pkg::TILT_RESET; ty_d = cme_pkg::TILT_RESET;
              end
              4'h1: if (wdata_q == cme_pkg::TILT_CAPTURE && armed_q) begin
                armed_d = 1'b0; tx_d = tilt(ax_q); ty_d = tilt(ay_q);
              end
              4'h8: begin
                cs_d = wdata_q[7];
                din_d = wdata_q[1];
                sck_d = wdata_q[6];
                if (wdata_q[7] && !sck_q && wdata_q[6]) begin
                  dout_d = out_sh_q[15];
                  out_sh_d = {out_sh_q[14:0], 1'b1};
                  if (bits_q == 5'd0) begin
                    nsh = {cmd_sh_q[9:0], wdata_q[1]};
                    cmd_sh_d = nsh;
                    if (nsh[10]) begin
                      op = nsh[9:6];
                      if (op[3:2] == 2'b10) begin
                        out_sh_d = rd_q;
                        cmd_sh_d = '0;
                      end else if (op == cme_pkg::OP_EWEN) begin
                        ewen_d = 1'b1; cmd_sh_d = '0;
                      end else if (op == cme_pkg::OP_EWDS) begin
                        ewen_d = 1'b0; cmd_sh_d = '0;
                      end else if (op[3:2] == 2'b01) begin
                        bits_d = 5'd16;
                        if (ewen_q) begin
                          wr_single = 1'b1; wr_single_data = 16'h0000;
                        end
                      end else if (op[3:2] == 2'b11) begin
                        if (ewen_q) begin
                          wr_single = 1'b1; wr_single_data = 16'hFFFF;
                          out_sh_d = 16'h3FFF;
                        end
                        cmd_sh_d = '0;
                      end else if (op == cme_pkg::OP_ERAL) begin
                        if (ewen_q) begin
                          need_set_d = 1'b1; out_sh_d = 16'h00FF;
                        end
                        cmd_sh_d = '0;
                      end else begin
                        bits_d = 5'd16;
                        need_clear_d = ewen_q;
                        if (ewen_q) fill_d = 16'h0000;
                      end
                    end
                  end else begin
                    bits_d = bits_q - 5'd1;
                    dout_d = 1'b1;
                    obit = 4'(bits_q - 5'd1);
                    if (wdata_q[1] && ewen_q) begin
                      if (cmd_sh_q[8]) begin
                        wr_single = 1'b1;
                        wr_single_data = rd_q | (16'd1 << obit);
                      end else begin
                        // After the clear every word holds the same pattern.
                        need_or_d = 1'b1;
                        fill_d = fill_q | (16'd1 << obit);
                      end
                    end
                    if (bits_q == 5'd1) begin
                      cmd_sh_d = '0; out_sh_d = 16'h3FFF;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        default: src_d = cme_pkg::SRC_SYSTEM;
      endcase
    end
  end

  // One write port shared by the single-word write of a request and the sweeps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_single) mem_q[widx] <= wr_single_data;
    else if (cmd_i.sweep_clear) mem_q[sweep_q] <= 16'h0000;
    else if (cmd_i.sweep_set) mem_q[sweep_q] <= 16'hFFFF;
    else if (cmd_i.sweep_or) mem_q[sweep_q] <= fill_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) rd_q <= mem_q[widx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mode_q <= mode_i; addr_q <= address_i; wdata_q <= write_data_i;
      ax_q <= accel_x_i; ay_q <= accel_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 8'hFF; bank_q <= 8'd1; en_lo_q <= 1'b0; en_hi_q <= 1'b0;
      tx_q <= cme_pkg::TILT_RESET; ty_q <= cme_pkg::TILT_RESET; armed_q <= 1'b1;
      dout_q <= 1'b1; din_q <= 1'b0; sck_q <= 1'b0; cs_q <= 1'b0;
      cmd_sh_q <= '0; out_sh_q <= 16'hFFFF; bits_q <= '0; ewen_q <= 1'b0;
      rdata_q <= '0; raddr_q <= '0; src_q <= cme_pkg::SRC_SYSTEM;
      sweep_q <= '0; fill_q <= '0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_data_i;
      if (cmd_i.exec) begin
        bank_q <= bank_d; en_lo_q <= en_lo_d; en_hi_q <= en_hi_d;
        tx_q <= tx_d; ty_q <= ty_d; armed_q <= armed_d;
        dout_q <= dout_d; din_q <= din_d; sck_q <= sck_d; cs_q <= cs_d;
        cmd_sh_q <= cmd_sh_d; out_sh_q <= out_sh_d; bits_q <= bits_d; ewen_q <= ewen_d;
        rdata_q <= rdata_d; raddr_q <= raddr_d; src_q <= src_d;
        fill_q <= fill_d; sweep_q <= '0;
      end else if (cmd_i.sweep_clear || cmd_i.sweep_set || cmd_i.sweep_or) begin
        sweep_q <= sweep_q + 7'd1;
      end
    end
  end

  assign sts_o.sweep_last = (sweep_q == 7'(Depth - 1));
  assign sts_o.need_clear = need_clear_d;
  assign sts_o.need_set = need_set_d;
  assign sts_o.need_or = need_or_d;

  assign read_data_o = rdata_q;
  assign rom_address_o = raddr_q;
  assign access_source_o = src_q;
  assign current_bank_o = bank_q;

`ifndef SYNTHESIS
  a_rom_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_q != cme_pkg::SRC_ROM) |-> (raddr_q == 22'd0)) else $error("stray rom address");
  a_data_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_q != cme_pkg::SRC_MAPPER) |-> (rdata_q == 8'd0)) else $error("stray data");
  a_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= 5'd16) else $error("data bit count overrun");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/cartridge_mapper_with_serial_eeprom_core.sv =====
// Cartridge mapper top level: one request in, one result out.
// A result is offered after the fetch and execute states; an EEPROM whole-array
// operation (ERAL, WRAL clear or WRAL data bit) adds a sweep over all 128 words,
// one word a cycle.
// Requests are taken one at a time: a new one is accepted only after the last result is taken.
// Reset clears the control and mapper registers (not the request capture or the array),
// then a pass over all 128 words fills the EEPROM with ones while requests are stalled.
`timescale 1ns / 1ps
`default_nettype none
module cartridge_mapper_with_serial_eeprom_core #(
  parameter int BANK_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [15:0]        address_i,
  input  wire logic [7:0]         write_data_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              read_data_o,
  output logic [21:0]             rom_address_o,
  output logic [1:0]              access_source_o,
  output logic [7:0]              current_bank_o
);

  cme_pkg::cmd_t cmd;
  cme_pkg::sts_t sts;

  cme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  cme_datapath #(.BankBits(BANK_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_data_i,
    .mode_i, .address_i, .write_data_i, .accel_x_i, .accel_y_i,
    .read_data_o, .rom_address_o, .access_source_o, .current_bank_o
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the cartridge mapper with serial EEPROM.
// Depends on cme_pkg and cartridge_mapper_with_serial_eeprom_core.
`timescale 1ns / 1ps
module testbench;

  localparam logic [3:0] OP_WRITE = 4'h4;
  localparam logic [3:0] OP_READ = 4'h8;
  localparam logic [3:0] OP_ERASE = 4'hC;
  localparam logic [7:0] PIN_CS = 8'h80;
  localparam logic [7:0] PIN_CLK = 8'h40;
  localparam logic [7:0] PIN_DI = 8'h02;
  localparam logic [15:0] REG_ARM = 16'hA000;
  localparam logic [15:0] REG_CAPTURE = 16'hA010;
  localparam logic [15:0] REG_PINS = 16'hA080;
  localparam int DRAIN_CYCLES = 140;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [21:0] raddr;
    logic [1:0]  source;
    logic [7:0]  bank;
  } mapper_result_t;

  class mapper_scoreboard;
    logic [7:0]  bank_mask;
    logic [7:0]  bank;
    bit          en_low, en_high, armed;
    logic [15:0] tilt_x, tilt_y;
    logic [15:0] words[128];
    bit          dout, din, sclk, cs, ew_enabled;
    logic [10:0] cmd_sr;
    logic [15:0] out_sr;
    int          bits_left;
    mapper_result_t awaited[$];
    int          errors;
    int          checked;

    function void reset_state();
      bank_mask = 8'hFF;
      bank = 8'd1;
      en_low = 0;
      en_high = 0;
      armed = 1;
      tilt_x = cme_pkg::TILT_RESET;
      tilt_y = cme_pkg::TILT_RESET;
      foreach (words[i]) words[i] = 16'hFFFF;
      dout = 1;
      din = 0;
      sclk = 0;
      cs = 0;
      ew_enabled = 0;
      cmd_sr = '0;
      out_sr = 16'hFFFF;
      bits_left = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [15:0] tilt_of(logic signed [15:0] a);
      int p, q;
      p = 112 * int'(a);
      q = (p < 0) ? -((-p) >>> 12) : (p >>> 12);
      return cme_pkg::TILT_CENTRE + q[15:0];
    endfunction

    function void run_command();
      logic [6:0] w;
      w = cmd_sr[6:0];
      case (cmd_sr[9:6])
        4'h8, 4'h9, 4'hA, 4'hB: begin
          out_sr = words[w];
          cmd_sr = '0;
        end
        cme_pkg::OP_EWEN: begin
          ew_enabled = 1;
          cmd_sr = '0;
        end
        cme_pkg::OP_EWDS: begin
          ew_enabled = 0;
          cmd_sr = '0;
        end
        4'h4, 4'h5, 4'h6, 4'h7: begin
          if (ew_enabled) words[w] = 16'h0000;
          bits_left = 16;
        end
        4'hC, 4'hD, 4'hE, 4'hF: begin
          if (ew_enabled) begin
            words[w] = 16'hFFFF;
            out_sr = 16'h3FFF;
          end
          cmd_sr = '0;
        end
        cme_pkg::OP_ERAL: begin
          if (ew_enabled) begin
            foreach (words[i]) words[i] = 16'hFFFF;
            out_sr = 16'h00FF;
          end
          cmd_sr = '0;
        end
        default: begin
          if (ew_enabled) foreach (words[i]) words[i] = 16'h0000;
          bits_left = 16;
        end
      endcase
    endfunction

    function void pins_write(logic [7:0] v);
      logic [15:0] b;
      cs = v[7];
      din = v[1];
      if (cs && !sclk && v[6]) begin
        dout = out_sr[15];
        out_sr = {out_sr[14:0], 1'b1};
        if (bits_left == 0) begin
          cmd_sr = {cmd_sr[9:0], din};
          if (cmd_sr[10]) run_command();
        end else begin
          bits_left--;
          dout = 1;
          if (din && ew_enabled) begin
            b = 16'h1 << bits_left;
            // Bit 8 of the command tells WRITE apart from WRAL.
            if (cmd_sr[8]) words[cmd_sr[6:0]] |= b;
            else foreach (words[i]) words[i] |= b;
          end
          if (bits_left == 0) begin
            cmd_sr = '0;
            out_sr = 16'h3FFF;
          end
        end
      end
      sclk = v[6];
    endfunction

    function logic [7:0] reg_read(logic [15:0] a);
      if (a >= 16'hB000) return 8'hFF;
      case (a[7:4])
        4'h2: return tilt_x[7:0];
        4'h3: return tilt_x[15:8];
        4'h4: return tilt_y[7:0];
        4'h5: return tilt_y[15:8];
        4'h6: return 8'h00;
        4'h8: return {cs, sclk, 4'b0, din, dout};
        default: return 8'hFF;
      endcase
    endfunction

    function void reg_write(logic [15:0] a, logic [7:0] v, logic [15:0] ax, logic [15:0] ay);
      if (a >= 16'hB000) return;
      case (a[7:4])
        4'h0: if (v == cme_pkg::TILT_ARM) begin
          armed = 1;
          tilt_x = cme_pkg::TILT_RESET;
          tilt_y = cme_pkg::TILT_RESET;
        end
        4'h1: if (v == cme_pkg::TILT_CAPTURE && armed) begin
          armed = 0;
          tilt_x = tilt_of(ax);
          tilt_y = tilt_of(ay);
        end
        4'h8: pins_write(v);
        default: ;
      endcase
    endfunction

    function void note_request(bit wr, logic [15:0] a, logic [7:0] v,
                               logic [15:0] ax, logic [15:0] ay);
      mapper_result_t r;
      logic [2:0] region;
      r = '0;
      r.source = cme_pkg::SRC_SYSTEM;
      region = a[15:13];
      if (!wr) begin
        if (region == 3'd2 || region == 3'd3) begin
          r.source = cme_pkg::SRC_ROM;
          r.raddr = {bank, a[13:0]};
        end else if (region == 3'd5) begin
          r.source = cme_pkg::SRC_MAPPER;
          r.rdata = (en_low && en_high) ? reg_read(a) : 8'hFF;
        end
      end else begin
        r.source = cme_pkg::SRC_ABSORB;
        case (region)
          3'd0: en_low = (v[3:0] == 4'hA);
          3'd1: bank = v & bank_mask;
          3'd2: en_high = (v == 8'h40);
          3'd3: ;
          3'd5: if (en_low && en_high) reg_write(a, v, ax, ay);
          default: r.source = cme_pkg::SRC_SYSTEM;
        endcase
      end
      r.bank = bank;
      awaited.push_back(r);
    endfunction

    function void check_result(mapper_result_t got);
      mapper_result_t exp_r;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual %h", $time, got);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      checked++;
      if (got.rdata !== exp_r.rdata) begin
        $display("%0t: read_data expected %h actual %h", $time, exp_r.rdata, got.rdata);
        errors++;
      end
      if (got.raddr !== exp_r.raddr) begin
        $display("%0t: rom_address expected %h actual %h", $time, exp_r.raddr, got.raddr);
        errors++;
      end
      if (got.source !== exp_r.source) begin
        $display("%0t: access_source expected %h actual %h", $time, exp_r.source,
                 got.source);
        errors++;
      end
      if (got.bank !== exp_r.bank) begin
        $display("%0t: current_bank expected %h actual %h", $time, exp_r.bank, got.bank);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic        mode_i = 0;
  logic [15:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [7:0]  read_data_o;
  logic [21:0] rom_address_o;
  logic [1:0]  access_source_o;
  logic [7:0]  current_bank_o;

  mapper_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_cycle = 0;
  int stall_style = 0;
  int sent = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  cartridge_mapper_with_serial_eeprom_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .mode_i, .address_i, .write_data_i,
    .accel_x_i, .accel_y_i,
    .out_valid_o, .out_stall_i, .read_data_o, .rom_address_o,
    .access_source_o, .current_bank_o
  );

  // Both handshakes are observed here with the values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(mode_i, address_i, write_data_i, accel_x_i, accel_y_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({read_data_o, rom_address_o, access_source_o, current_bank_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      // The receiver switches at random among four stall styles.
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 200 == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= (stall_cycle % 7 < 3);
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic send_request(bit wr, logic [15:0] a, logic [7:0] v,
                              logic [15:0] ax = 16'($urandom),
                              logic [15:0] ay = 16'($urandom));
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= wr;
    address_i <= a;
    write_data_i <= v;
    accel_x_i <= ax;
    accel_y_i <= ay;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [7:0] m);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    sb.bank_mask = m;
    cfg_we_i <= 1'b0;
  endtask

  task automatic clock_pin_bit(bit b);
    send_request(1, REG_PINS, PIN_CS | (b ? PIN_DI : 8'h00));
    send_request(1, REG_PINS, PIN_CS | PIN_CLK | (b ? PIN_DI : 8'h00));
  endtask

  // A well-formed serial transaction: start bit, opcode and address,
  // then data bits or a read-back of the output shift register.
  task automatic eeprom_transaction();
    logic [3:0]  op;
    logic [9:0]  cmd;
    logic [15:0] data;
    case ($urandom_range(0, 6))
      0: op = OP_READ | 4'($urandom_range(0, 3));
      1: op = cme_pkg::OP_EWEN;
      2: op = cme_pkg::OP_EWDS;
      3: op = OP_WRITE | 4'($urandom_range(0, 3));
      4: op = OP_ERASE | 4'($urandom_range(0, 3));
      5: op = cme_pkg::OP_ERAL;
      default: op = cme_pkg::OP_WRAL;
    endcase
    cmd = {op, 6'($urandom)};
    data = 16'($urandom);
    send_request(1, REG_PINS, 8'h00);
    clock_pin_bit(1'b1);
    for (int i = 9; i >= 0; i--) clock_pin_bit(cmd[i]);
    if (op[3:2] == 2'b01 || op == cme_pkg::OP_WRAL)
      for (int i = 15; i >= 0; i--) clock_pin_bit(data[i]);
    for (int i = 0; i < $urandom_range(0, 17); i++) begin
      clock_pin_bit(1'($urandom_range(0, 1)));
      send_request(0, REG_PINS | 16'($urandom_range(0, 15)), 8'h00);
    end
    send_request(1, REG_PINS, 8'h00);
  endtask

  task automatic enable_window();
    send_request(1, 16'($urandom_range(0, 16'h1FFF)), {4'($urandom), 4'hA});
    send_request(1, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)), 8'h40);
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 3) == 0) enable_window();
          if ($urandom_range(0, 2) == 0) begin
            send_request(1, REG_PINS, 8'h00);
            clock_pin_bit(1'b1);
            for (int i = 9; i >= 0; i--) clock_pin_bit(i == 7 || i == 6);
          end
          eeprom_transaction();
        end
        4: begin
          send_request(1, REG_ARM | 16'($urandom_range(0, 15)),
                       $urandom_range(0, 1) ? cme_pkg::TILT_ARM : 8'($urandom));
          send_request(1, REG_CAPTURE | 16'($urandom_range(0, 15)),
                       $urandom_range(0, 3) ? cme_pkg::TILT_CAPTURE : 8'($urandom));
          for (int i = 2; i <= 5; i++) send_request(0, 16'hA000 | 16'(i << 4), 8'h00);
        end
        5: send_request(1, 16'h2000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        6: enable_window();
        7: send_request(0, 16'h4000 | 16'($urandom_range(0, 16'h3FFF)), 8'($urandom));
        8: send_request(1, 16'hA000 | 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
        default: send_request(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mask(8'hFF);

    // Directed: address map corners, disabled window, bank zero, tilt extremes.
    send_request(0, 16'h4000, 8'h00);
    send_request(0, 16'h7FFF, 8'hFF);
    send_request(0, 16'h0000, 8'h00);
    send_request(0, 16'hFFFF, 8'h00);
    send_request(0, 16'hA020, 8'h00);
    send_request(1, 16'hE000, 8'hFF);
    send_request(1, 16'h0000, 8'h0A);
    send_request(1, 16'h4000, 8'h40);
    send_request(1, 16'h2000, 8'h00);
    send_request(0, 16'h7FFF, 8'h00);
    send_request(1, 16'h3FFF, 8'hFF);
    send_request(0, 16'h5555, 8'h00);
    send_request(1, REG_CAPTURE, cme_pkg::TILT_CAPTURE, 16'sh8000, 16'sh7FFF);
    for (int i = 2; i <= 6; i++) send_request(0, 16'hA000 | 16'(i << 4), 8'h00);
    send_request(0, 16'hA070, 8'h00);
    send_request(0, 16'hB000, 8'h00);
    send_request(1, 16'hB080, 8'hC2);
    send_request(0, REG_PINS, 8'h00);
    send_request(1, REG_ARM, cme_pkg::TILT_ARM);
    send_request(1, REG_CAPTURE, cme_pkg::TILT_CAPTURE, 16'sh7FFF, 16'sh8000);
    send_request(0, 16'hA030, 8'h00);

    random_phase(100);
    drain();
    write_mask(8'h00);
    random_phase(100);
    drain();
    write_mask(8'h0F);
    random_phase(100);
    drain();
    write_mask(8'($urandom));
    random_phase(100);
    drain();

    $display("Sent %0d requests and checked %0d results over four bank mask settings,",
             sent, sb.checked);
    $display("with EEPROM command sequences, tilt captures and random accesses.");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/cme_pkg.sv
hw/rtl/cme_ctrl.sv
hw/rtl/cme_datapath.sv
hw/rtl/cartridge_mapper_with_serial_eeprom_core.sv
verif/testbench.sv
